/* rtl/hic_pkg.sv */
// Shared types and constants for the hard-iron min/max calibration block.
// No dependencies.
package hic_pkg;

    localparam int AXIS_W  = 16;
    localparam int QUIET_W = 18;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic signed [AXIS_W-1:0] AXIS_MAX_VAL = 16'sh7FFF;
    localparam logic signed [AXIS_W-1:0] AXIS_MIN_VAL = 16'sh8000;
    localparam logic [QUIET_W-1:0]       QUIET_TOP    = 18'h3FFFF;
    localparam logic [QUIET_W-1:0]       SETTLE_RESET = 18'd130;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [AXIS_W-1:0] sample_x;
        logic signed [AXIS_W-1:0] sample_y;
        logic signed [AXIS_W-1:0] sample_z;
    } in_item_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] offset_x;
        logic signed [AXIS_W-1:0] offset_y;
        logic signed [AXIS_W-1:0] offset_z;
    } out_item_t;

    // control from the sequencer to the lanes and the output stage
    typedef struct packed {
        logic start;
        logic sample_upd;
        logic emit;
    } hic_ctl_t;

endpackage

/* rtl/hic_lane.sv */
// One axis lane: min/max tracker and truncating midpoint.
// Depends on hic_pkg.
module hic_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hic_pkg::hic_ctl_t                  ctl,
    input  logic signed [hic_pkg::AXIS_W-1:0]  sample,
    output logic                               changed,
    output logic signed [hic_pkg::AXIS_W-1:0]  offset
);

    logic signed [hic_pkg::AXIS_W-1:0] min_reg, min_next;
    logic signed [hic_pkg::AXIS_W-1:0] max_reg, max_next;
    logic signed [hic_pkg::AXIS_W-1:0] upd_min, upd_max;
    logic signed [hic_pkg::AXIS_W:0]   sum;
    logic signed [hic_pkg::AXIS_W:0]   sum_adj;
    logic                              lt_min, gt_max;

    assign lt_min  = sample < min_reg;
    assign gt_max  = sample > max_reg;
    assign changed = lt_min || gt_max;
    assign upd_min = lt_min ? sample : min_reg;
    assign upd_max = gt_max ? sample : max_reg;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctl.start) begin
            min_next = hic_pkg::AXIS_MAX_VAL;
            max_next = hic_pkg::AXIS_MIN_VAL;
        end else if (ctl.sample_upd) begin
            min_next = upd_min;
            max_next = upd_max;
        end
    end

    // midpoint of the updated extremes, rounded toward zero
    assign sum     = {upd_min[hic_pkg::AXIS_W-1], upd_min}
                   + {upd_max[hic_pkg::AXIS_W-1], upd_max};
    assign sum_adj = sum + {{hic_pkg::AXIS_W{1'b0}}, sum[hic_pkg::AXIS_W]};
    assign offset  = sum_adj[hic_pkg::AXIS_W:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= hic_pkg::AXIS_MAX_VAL;
            max_reg <= hic_pkg::AXIS_MIN_VAL;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    a_ordered_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.sample_upd && !ctl.start |=> min_reg <= max_reg)
        else $error("lane extremes out of order after a sample");

endmodule

/* rtl/hic_ctrl.sv */
// Sequencer: armed flag, quiet-time counter, settle register, emit decision.
// Depends on hic_pkg.
module hic_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [hic_pkg::QUIET_W-1:0]    cfg_wr_data,
    input  logic                           accept,
    input  logic [1:0]                     command,
    input  logic                           changed_any,
    output hic_pkg::hic_ctl_t              ctl
);

    logic                        armed_reg, armed_next;
    logic [hic_pkg::QUIET_W-1:0] quiet_reg, quiet_next;
    logic [hic_pkg::QUIET_W-1:0] settle_reg;
    logic [hic_pkg::QUIET_W-1:0] quiet_after;
    logic                        is_tick;

    assign ctl.start      = accept && (command == hic_pkg::CMD_START);
    assign ctl.sample_upd = accept && armed_reg && (command == hic_pkg::CMD_SAMPLE);
    assign is_tick        = accept && armed_reg && (command == hic_pkg::CMD_TICK);

    // a new extreme restarts quiet time before the settle check
    assign quiet_after = changed_any ? '0 : quiet_reg;
    assign ctl.emit    = ctl.sample_upd && (quiet_after >= settle_reg);

    always_comb begin
        armed_next = armed_reg;
        quiet_next = quiet_reg;
        if (ctl.start) begin
            armed_next = 1'b1;
            quiet_next = '0;
        end else if (ctl.sample_upd) begin
            quiet_next = quiet_after;
            if (ctl.emit) begin
                armed_next = 1'b0;
            end
        end else if (is_tick && quiet_reg != hic_pkg::QUIET_TOP) begin
            quiet_next = quiet_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg  <= 1'b0;
            quiet_reg  <= '0;
            settle_reg <= hic_pkg::SETTLE_RESET;
        end else begin
            armed_reg <= armed_next;
            quiet_reg <= quiet_next;
            if (cfg_wr_en) begin
                settle_reg <= cfg_wr_data;
            end
        end
    end

    a_emit_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |=> !armed_reg)
        else $error("block still armed after emitting offsets");

    a_change_clears_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.sample_upd && changed_any |=> quiet_reg == '0)
        else $error("quiet counter not cleared by a new extreme");

    a_tick_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        is_tick && quiet_reg != hic_pkg::QUIET_TOP |=> quiet_reg == $past(quiet_reg) + 1'b1)
        else $error("tick did not advance the quiet counter");

endmodule

/* rtl/hard_iron_minmax_calibration.sv */
// Hard-iron min/max calibration, top level: three axis lanes, sequencer,
// output register. Depends on hic_pkg, hic_lane, hic_ctrl.
// Offsets appear on m_item in the cycle after the finishing sample item.
// Throughput: one item per cycle; every command is a single register update
//   in the lanes and the sequencer, and the output register frees s_ready
//   whenever it is empty or being drained.
// Reset (aresetn low, synchronous): disarmed, quiet count 0, settle_ms 130,
//   extremes at their cleared values, no result pending.
module hard_iron_minmax_calibration (
    input  logic                                aclk,
    input  logic                                aresetn,
    // settle_ms register
    input  logic                                cfg_wr_en,
    input  logic [hic_pkg::QUIET_W-1:0]         cfg_wr_data,
    // command / sample items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  hic_pkg::in_item_t                   s_item,
    // offset results
    output logic                                m_valid,
    input  logic                                m_ready,
    output hic_pkg::out_item_t                  m_item
);

    hic_pkg::hic_ctl_t  ctl;
    hic_pkg::out_item_t out_reg, out_next;
    logic               m_valid_reg, m_valid_next;
    logic               accept;
    logic [2:0]         lane_changed;
    logic signed [hic_pkg::AXIS_W-1:0] lane_sample [3];
    logic signed [hic_pkg::AXIS_W-1:0] lane_offset [3];

    // An item can enter whenever the output slot is empty or drains this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign lane_sample[0] = s_item.sample_x;
    assign lane_sample[1] = s_item.sample_y;
    assign lane_sample[2] = s_item.sample_z;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        hic_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .sample  (lane_sample[i]),
            .changed (lane_changed[i]),
            .offset  (lane_offset[i])
        );
    end

    // merge: any lane that saw a new extreme restarts quiet time
    hic_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .command     (s_item.command),
        .changed_any (|lane_changed),
        .ctl         (ctl)
    );

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (ctl.emit) begin
            out_next.offset_x = lane_offset[0];
            out_next.offset_y = lane_offset[1];
            out_next.offset_z = lane_offset[2];
            m_valid_next      = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule
